// File: hdl/hrhp_pkg.sv
package hrhp_pkg;

	typedef enum logic [3:0] {
		ST_PROTO = 4'd0,
		ST_CODE  = 4'd1,
		ST_TEXT  = 4'd2,
		ST_NL1   = 4'd3,
		ST_KEY   = 4'd4,
		ST_SPACE = 4'd5,
		ST_VALUE = 4'd6,
		ST_NL2   = 4'd7,
		ST_NL3   = 4'd8,
		ST_BODY  = 4'd9,
		ST_DONE  = 4'd10,
		ST_BAD   = 4'd11,
		ST_LARGE = 4'd12
	} stage_t;

	localparam logic [1:0] STAT_CONT  = 2'd0;
	localparam logic [1:0] STAT_DONE  = 2'd1;
	localparam logic [1:0] STAT_BAD   = 2'd2;
	localparam logic [1:0] STAT_LARGE = 2'd3;

	localparam logic CFG_HEAD = 1'b0;
	localparam logic CFG_MAX  = 1'b1;

	localparam int CFG_IDX_W = 8;

	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_SEMI  = 8'h3b;

	function automatic logic [7:0] lower(input logic [7:0] c);
		lower = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
	endfunction

	function automatic logic is_ctl(input logic [7:0] c);
		is_ctl = (c < 8'h20) || (c == 8'h7f);
	endfunction

	function automatic logic [7:0] proto_chr(input logic [2:0] i);
		case (i)
			3'd0: proto_chr = "H";
			3'd1: proto_chr = "T";
			3'd2: proto_chr = "T";
			3'd3: proto_chr = "P";
			3'd4: proto_chr = "/";
			3'd5: proto_chr = "1";
			default: proto_chr = ".";
		endcase
	endfunction

	function automatic logic [7:0] ka_chr(input logic [3:0] i);
		case (i)
			4'd0: ka_chr = "k";
			4'd1: ka_chr = "e";
			4'd2: ka_chr = "e";
			4'd3: ka_chr = "p";
			4'd4: ka_chr = "-";
			4'd5: ka_chr = "a";
			4'd6: ka_chr = "l";
			4'd7: ka_chr = "i";
			4'd8: ka_chr = "v";
			4'd9: ka_chr = "e";
			default: ka_chr = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] gz_chr(input logic [1:0] i);
		case (i)
			2'd0: gz_chr = "g";
			2'd1: gz_chr = "z";
			2'd2: gz_chr = "i";
			default: gz_chr = "p";
		endcase
	endfunction

	function automatic logic [7:0] ch_chr(input logic [2:0] i);
		case (i)
			3'd0: ch_chr = "c";
			3'd1: ch_chr = "h";
			3'd2: ch_chr = "u";
			3'd3: ch_chr = "n";
			3'd4: ch_chr = "k";
			3'd5: ch_chr = "e";
			3'd6: ch_chr = "d";
			default: ch_chr = 8'h00;
		endcase
	endfunction

	// key 0 connection, 1 content-length, 2 transfer-encoding, 3 content-encoding
	function automatic logic [7:0] key_chr(input logic [1:0] k, input logic [4:0] i);
		logic [8*17-1:0] s;
		logic [4:0] n;
		begin
			case (k)
				2'd0: begin s = {56'b0, "noitcennoc"}; n = 5'd10; end
				2'd1: begin s = {24'b0, "htgnel-tnetnoc"}; n = 5'd14; end
				2'd2: begin s = "gnidocne-refsnart"; n = 5'd17; end
				default: begin s = {8'b0, "gnidocne-tnetnoc"}; n = 5'd16; end
			endcase
			key_chr = (i < n) ? s[i*8 +: 8] : 8'h00;
		end
	endfunction

	function automatic logic [4:0] key_len(input logic [1:0] k);
		case (k)
			2'd0: key_len = 5'd10;
			2'd1: key_len = 5'd14;
			2'd2: key_len = 5'd17;
			default: key_len = 5'd16;
		endcase
	endfunction

endpackage

// File: hdl/http_response_head_parser_top.sv
// http response head parser, one byte per transfer
// s_axis: tdata = rx_byte [7:0]
// m_axis: one result transfer per accepted byte, fields listed at the port
// cfg: index 0 is_head_request, index 1 max_body_bytes; write only while idle
// latency: a result is shown one cycle after its byte is taken
// throughput: one byte per cycle; the whole per-byte parse step sits between
// the accepted byte and the result register
// a result register holds the output; s_axis_tready is high whenever that
// register is empty or being taken in the same cycle, so a stalled receiver
// stops input after at most one held result
// reset clears the parse state, the reported header values, the body count
// and the configuration (not HEAD, no body limit)
// after completion or an error further bytes are absorbed with the status held
// parameter STATUS_TEXT_LIMIT: longest status text is this plus one bytes
module http_response_head_parser_top #(
	parameter int STATUS_TEXT_LIMIT = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [1:0] status, [2] body_valid, [10:3] body_byte, [12:11] version,
	// [28:13] http_code, [29] keep_alive, [30] chunked, [31] gzip,
	// [95:32] body_length
	output logic [95:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [hrhp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int TC_W = $clog2(STATUS_TEXT_LIMIT + 2);

	hrhp_pkg::stage_t stage_q, stage_d;
	logic [TC_W-1:0] tcnt_q, tcnt_d;
	logic            pmiss_q, pmiss_d;
	logic [1:0]      pver_q, pver_d;
	logic            dopen_q, dopen_d;
	logic [15:0]     code_q, code_d;
	logic [3:0]      kc_q, kc_d;
	logic [4:0]      klen_q, klen_d;
	logic            vka_q, vka_d, vce_q, vce_d, vcl_q, vcl_d, vch_q, vch_d, vgz_q, vgz_d;
	logic [4:0]      vlen_q, vlen_d;
	logic [63:0]     lacc_q, lacc_d;
	logic            sg_st_q, sg_st_d, sg_gap_q, sg_gap_d, sg_mc_q, sg_mc_d, sg_mg_q, sg_mg_d;
	logic [3:0]      sg_len_q, sg_len_d;
	logic [1:0]      ver_q, ver_d;
	logic [15:0]     scode_q, scode_d;
	logic            ka_q, ka_d, chk_q, chk_d, gz_q, gz_d;
	logic [63:0]     blen_q, blen_d;
	logic [63:0]     saved_q, saved_d;
	logic            head_q;
	logic [63:0]     maxb_q;

	logic            ovalid_q;
	logic [95:0]     odata_q;
	logic            body;
	logic [1:0]      st;
	logic            take;

	assign s_axis_tready = !ovalid_q || m_axis_tready;
	assign take = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = odata_q;

	always_comb begin
		logic [7:0] ch, c;
		logic [19:0] cx;
		logic [67:0] lx;
		logic [3:0] d;
		logic segend, seg_hit_ch, seg_hit_gz;
		ch = s_axis_tdata;
		c = hrhp_pkg::lower(ch);
		d = ch[3:0];
		cx = '0;
		lx = '0;
		segend = 1'b0;
		body = 1'b0;
		stage_d = stage_q; tcnt_d = tcnt_q; pmiss_d = pmiss_q; pver_d = pver_q;
		dopen_d = dopen_q; code_d = code_q; kc_d = kc_q; klen_d = klen_q;
		vka_d = vka_q; vce_d = vce_q; vcl_d = vcl_q; vch_d = vch_q; vgz_d = vgz_q;
		vlen_d = vlen_q; lacc_d = lacc_q;
		sg_st_d = sg_st_q; sg_gap_d = sg_gap_q; sg_mc_d = sg_mc_q; sg_mg_d = sg_mg_q;
		sg_len_d = sg_len_q;
		ver_d = ver_q; scode_d = scode_q; ka_d = ka_q; chk_d = chk_q; gz_d = gz_q;
		blen_d = blen_q; saved_d = saved_q;
		seg_hit_ch = sg_st_q && sg_mc_q && sg_len_q == 4'd7;
		seg_hit_gz = sg_st_q && sg_mg_q && sg_len_q == 4'd4;
		case (stage_q)
			hrhp_pkg::ST_PROTO: begin
				if (ch == hrhp_pkg::CH_SP) begin
					if (tcnt_q < TC_W'(8) || pmiss_q) begin
						stage_d = hrhp_pkg::ST_BAD;
					end else begin
						ver_d = pver_q;
						stage_d = hrhp_pkg::ST_CODE;
						code_d = '0;
						dopen_d = 1'b1;
					end
				end else if (tcnt_q > TC_W'(8)) begin
					stage_d = hrhp_pkg::ST_BAD;
				end else begin
					if (tcnt_q < TC_W'(7)) begin
						if (ch != hrhp_pkg::proto_chr(tcnt_q[2:0])) pmiss_d = 1'b1;
					end else if (tcnt_q == TC_W'(7)) begin
						if (ch == "1") pver_d = 2'd2;
						else if (ch == "0") pver_d = 2'd1;
						else pmiss_d = 1'b1;
					end
					tcnt_d = tcnt_q + 1'b1;
				end
			end
			hrhp_pkg::ST_CODE: begin
				if (ch == hrhp_pkg::CH_SP) begin
					if (code_q == 16'd0) begin
						stage_d = hrhp_pkg::ST_BAD;
					end else begin
						scode_d = code_q;
						stage_d = hrhp_pkg::ST_TEXT;
						tcnt_d = '0;
					end
				end else if (hrhp_pkg::is_ctl(ch)) begin
					stage_d = hrhp_pkg::ST_BAD;
				end else if (dopen_q && ch >= "0" && ch <= "9") begin
					cx = {code_q, 3'b0} + {code_q, 1'b0} + 20'(d);
					code_d = (cx > 20'd65535) ? 16'hffff : cx[15:0];
				end else begin
					dopen_d = 1'b0;
				end
			end
			hrhp_pkg::ST_TEXT: begin
				if (ch == hrhp_pkg::CH_CR) stage_d = hrhp_pkg::ST_NL1;
				else if (tcnt_q > TC_W'(STATUS_TEXT_LIMIT)) stage_d = hrhp_pkg::ST_BAD;
				else tcnt_d = tcnt_q + 1'b1;
			end
			hrhp_pkg::ST_NL1, hrhp_pkg::ST_NL2: begin
				if (ch == hrhp_pkg::CH_LF) begin
					stage_d = hrhp_pkg::ST_KEY;
					kc_d = 4'hf;
					klen_d = '0;
				end else begin
					stage_d = hrhp_pkg::ST_BAD;
				end
			end
			hrhp_pkg::ST_KEY: begin
				if (ch == hrhp_pkg::CH_CR) begin
					stage_d = (klen_q != 5'd0) ? hrhp_pkg::ST_BAD : hrhp_pkg::ST_NL3;
				end else if (ch == hrhp_pkg::CH_COLON) begin
					for (int i = 0; i < 4; i++)
						if (klen_q != hrhp_pkg::key_len(2'(i))) kc_d[i] = 1'b0;
					vka_d = 1'b1; vce_d = 1'b1; vcl_d = 1'b1; vch_d = 1'b0; vgz_d = 1'b0;
					vlen_d = '0;
					lacc_d = '0;
					sg_st_d = 1'b0; sg_gap_d = 1'b0; sg_mc_d = 1'b1; sg_mg_d = 1'b1;
					sg_len_d = '0;
					stage_d = hrhp_pkg::ST_SPACE;
				end else if (hrhp_pkg::is_ctl(ch)) begin
					stage_d = hrhp_pkg::ST_BAD;
				end else begin
					for (int i = 0; i < 4; i++)
						if (!(klen_q < hrhp_pkg::key_len(2'(i))
							&& hrhp_pkg::key_chr(2'(i), klen_q) == c)) kc_d[i] = 1'b0;
					if (klen_q < 5'd31) klen_d = klen_q + 1'b1;
				end
			end
			hrhp_pkg::ST_SPACE: begin
				stage_d = (ch == hrhp_pkg::CH_SP) ? hrhp_pkg::ST_VALUE : hrhp_pkg::ST_BAD;
			end
			hrhp_pkg::ST_VALUE: begin
				if (ch == hrhp_pkg::CH_CR) begin
					stage_d = hrhp_pkg::ST_NL2;
					if (kc_q[0]) ka_d = vka_q && vlen_q == 5'd10;
					if (kc_q[1] && vcl_q) blen_d = lacc_q;
					if (kc_q[2]) begin
						if (vch_q || seg_hit_ch) chk_d = 1'b1;
						if (vgz_q || (!seg_hit_ch && seg_hit_gz)) gz_d = 1'b1;
					end
					if (kc_q[3] && vce_q && vlen_q == 5'd4) gz_d = 1'b1;
					sg_st_d = 1'b0; sg_gap_d = 1'b0; sg_mc_d = 1'b1; sg_mg_d = 1'b1;
					sg_len_d = '0;
				end else if (hrhp_pkg::is_ctl(ch)) begin
					stage_d = hrhp_pkg::ST_BAD;
				end else begin
					if (!(vlen_q < 5'd10 && hrhp_pkg::ka_chr(vlen_q[3:0]) == c)) vka_d = 1'b0;
					if (!(vlen_q < 5'd4 && hrhp_pkg::gz_chr(vlen_q[1:0]) == c)) vce_d = 1'b0;
					if (vlen_q < 5'd31) vlen_d = vlen_q + 1'b1;
					if (ch >= "0" && ch <= "9") begin
						lx = {lacc_q, 3'b0} + {lacc_q, 1'b0} + 68'(d);
						if (lx[67:64] != 4'd0) vcl_d = 1'b0;
						else if (vcl_q) lacc_d = lx[63:0];
					end else begin
						vcl_d = 1'b0;
					end
					if (ch == hrhp_pkg::CH_COMMA || ch == hrhp_pkg::CH_SEMI) begin
						segend = 1'b1;
					end else if (ch == hrhp_pkg::CH_SP || ch == hrhp_pkg::CH_TAB) begin
						if (sg_st_q) sg_gap_d = 1'b1;
					end else begin
						sg_st_d = 1'b1;
						if (sg_gap_q || !(sg_len_q < 4'd7 && hrhp_pkg::ch_chr(sg_len_q[2:0]) == c))
							sg_mc_d = 1'b0;
						if (sg_gap_q || !(sg_len_q < 4'd4 && hrhp_pkg::gz_chr(sg_len_q[1:0]) == c))
							sg_mg_d = 1'b0;
						if (sg_len_q < 4'd15) sg_len_d = sg_len_q + 1'b1;
					end
					if (segend) begin
						if (seg_hit_ch) vch_d = 1'b1;
						else if (seg_hit_gz) vgz_d = 1'b1;
						sg_st_d = 1'b0; sg_gap_d = 1'b0; sg_mc_d = 1'b1; sg_mg_d = 1'b1;
						sg_len_d = '0;
					end
				end
			end
			hrhp_pkg::ST_NL3: begin
				if (ch == hrhp_pkg::CH_LF) begin
					if ((!chk_q && blen_q == 64'd0) || head_q) stage_d = hrhp_pkg::ST_DONE;
					else stage_d = hrhp_pkg::ST_BODY;
				end else begin
					stage_d = hrhp_pkg::ST_BAD;
				end
			end
			hrhp_pkg::ST_BODY: begin
				if (saved_q >= maxb_q) begin
					stage_d = hrhp_pkg::ST_LARGE;
				end else begin
					saved_d = saved_q + 64'd1;
					body = 1'b1;
					if (saved_q + 64'd1 >= blen_q) stage_d = hrhp_pkg::ST_DONE;
				end
			end
			default: ;
		endcase
		case (stage_d)
			hrhp_pkg::ST_BAD:   st = hrhp_pkg::STAT_BAD;
			hrhp_pkg::ST_LARGE: st = hrhp_pkg::STAT_LARGE;
			hrhp_pkg::ST_DONE:  st = hrhp_pkg::STAT_DONE;
			default:            st = hrhp_pkg::STAT_CONT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= hrhp_pkg::ST_PROTO;
			tcnt_q <= '0; pmiss_q <= 1'b0; pver_q <= '0; dopen_q <= 1'b1; code_q <= '0;
			kc_q <= 4'hf; klen_q <= '0;
			vka_q <= 1'b0; vce_q <= 1'b0; vcl_q <= 1'b0; vch_q <= 1'b0; vgz_q <= 1'b0;
			vlen_q <= '0; lacc_q <= '0;
			sg_st_q <= 1'b0; sg_gap_q <= 1'b0; sg_mc_q <= 1'b1; sg_mg_q <= 1'b1;
			sg_len_q <= '0;
			ver_q <= '0; scode_q <= '0; ka_q <= 1'b0; chk_q <= 1'b0; gz_q <= 1'b0;
			blen_q <= '0; saved_q <= '0;
			head_q <= 1'b0;
			maxb_q <= '1;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == hrhp_pkg::CFG_IDX_W'(hrhp_pkg::CFG_HEAD)) head_q <= cfg_data[0];
				else if (cfg_index == hrhp_pkg::CFG_IDX_W'(hrhp_pkg::CFG_MAX)) maxb_q <= cfg_data;
			end
			if (take) begin
				stage_q <= stage_d;
				tcnt_q <= tcnt_d; pmiss_q <= pmiss_d; pver_q <= pver_d; dopen_q <= dopen_d;
				code_q <= code_d; kc_q <= kc_d; klen_q <= klen_d;
				vka_q <= vka_d; vce_q <= vce_d; vcl_q <= vcl_d; vch_q <= vch_d; vgz_q <= vgz_d;
				vlen_q <= vlen_d; lacc_q <= lacc_d;
				sg_st_q <= sg_st_d; sg_gap_q <= sg_gap_d; sg_mc_q <= sg_mc_d; sg_mg_q <= sg_mg_d;
				sg_len_q <= sg_len_d;
				ver_q <= ver_d; scode_q <= scode_d; ka_q <= ka_d; chk_q <= chk_d; gz_q <= gz_d;
				blen_q <= blen_d; saved_q <= saved_d;
				ovalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			odata_q <= {blen_d, gz_d, chk_d, ka_d, scode_d, ver_d,
				(body ? s_axis_tdata : 8'h00), body, st};
		end
	end

	a_body_done: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_q == hrhp_pkg::ST_DONE) |=> (stage_q == hrhp_pkg::ST_DONE))
		else $error("completion not sticky");
	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_q == hrhp_pkg::ST_BAD) |=> (stage_q == hrhp_pkg::ST_BAD))
		else $error("error not sticky");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken over a held result");
	a_saved: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_q != hrhp_pkg::ST_BODY) |=> $stable(saved_q))
		else $error("body count moved outside body");
	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_q == hrhp_pkg::ST_BODY && take) |=> (saved_q <= maxb_q))
		else $error("body count beyond limit");

endmodule

// File: dv/testbench.sv
module testbench;

	typedef enum logic [1:0] {P_BYTE, P_CFG, P_PAUSE} pend_kind_t;

	typedef struct {
		pend_kind_t kind;
		logic [7:0] idx;
		logic [63:0] value;
	} pend_t;

	typedef struct {
		logic [1:0] status;
		logic body_valid;
		logic [7:0] body_byte;
		logic [1:0] version;
		logic [15:0] http_code;
		logic keep_alive;
		logic chunked;
		logic gzip;
		logic [63:0] body_length;
	} resp_t;

	localparam int TEXT_LIMIT = 128;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_HEADERS = 12;
	localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

	localparam logic [7:0] VF_KA = 8'd1;
	localparam logic [7:0] VF_CE = 8'd2;
	localparam logic [7:0] VF_CL = 8'd4;
	localparam logic [7:0] VF_CH = 8'd8;
	localparam logic [7:0] VF_GZ = 8'd16;

	localparam logic [3:0] KEY_CONN = 4'd1;
	localparam logic [3:0] KEY_CLEN = 4'd2;
	localparam logic [3:0] KEY_TENC = 4'd4;
	localparam logic [3:0] KEY_CENC = 4'd8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = 8'd0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [hrhp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0] cfg_data = 64'd0;

	http_response_head_parser_top #(.STATUS_TEXT_LIMIT(TEXT_LIMIT)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	pend_t pending[$];
	resp_t expected_resp[$];
	int errors = 0;
	int cyc = 0;
	int bytes_in = 0;
	int bytes_queued = 0;
	int results_out = 0;
	int body_seen = 0;
	logic s_fire = 1'b0;
	logic cfg_fire = 1'b0;

	// parser copy
	logic cfg_head = 1'b0;
	logic [63:0] cfg_max = ALL_ONES;
	hrhp_pkg::stage_t stage = hrhp_pkg::ST_PROTO;
	int unsigned tok_cnt = 0;
	logic proto_miss = 1'b0;
	logic [1:0] ver_pend = 2'd0;
	logic digits_open = 1'b1;
	int unsigned code_acc = 0;
	logic [3:0] keys = 4'hf;
	int unsigned key_len = 0;
	logic [7:0] vflags = 8'd0;
	int unsigned val_len = 0;
	logic [63:0] len_acc = 64'd0;
	logic tk_started = 1'b0, tk_gap = 1'b0, tk_may_ch = 1'b1, tk_may_gz = 1'b1;
	int unsigned tk_len = 0;
	logic [1:0] r_version = 2'd0;
	logic [15:0] r_code = 16'd0;
	logic r_ka = 1'b0, r_ch = 1'b0, r_gz = 1'b0;
	logic [63:0] r_len = 64'd0;
	logic [63:0] body_count = 64'd0;

	string key_names[4] = '{"connection", "content-length", "transfer-encoding",
		"content-encoding"};
	string proto_str = "HTTP/1.";
	string ka_str = "keep-alive";
	string gz_str = "gzip";
	string ch_str = "chunked";

	function automatic logic [7:0] to_lower(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic logic ctl_byte(logic [7:0] c);
		return c < 8'h20 || c == 8'h7f;
	endfunction

	function automatic void token_reset();
		tk_started = 0; tk_gap = 0; tk_may_ch = 1; tk_may_gz = 1; tk_len = 0;
	endfunction

	function automatic void token_end();
		if (tk_started) begin
			if (tk_may_ch && tk_len == 7) vflags |= VF_CH;
			else if (tk_may_gz && tk_len == 4) vflags |= VF_GZ;
		end
		token_reset();
	endfunction

	function automatic void token_feed(logic [7:0] b);
		logic [7:0] c;
		c = to_lower(b);
		if (b == hrhp_pkg::CH_COMMA || b == hrhp_pkg::CH_SEMI) begin
			token_end();
		end else if (b == hrhp_pkg::CH_SP || b == hrhp_pkg::CH_TAB) begin
			if (tk_started) tk_gap = 1;
		end else begin
			tk_started = 1;
			if (tk_gap) begin
				tk_may_ch = 0; tk_may_gz = 0;
			end
			if (!(tk_len < 7 && ch_str[tk_len] == c)) tk_may_ch = 0;
			if (!(tk_len < 4 && gz_str[tk_len] == c)) tk_may_gz = 0;
			if (tk_len < 15) tk_len++;
		end
	endfunction

	function automatic void value_byte(logic [7:0] b);
		logic [7:0] c;
		logic [63:0] d;
		c = to_lower(b);
		if (!(val_len < 10 && ka_str[val_len] == c)) vflags &= ~VF_KA;
		if (!(val_len < 4 && gz_str[val_len] == c)) vflags &= ~VF_CE;
		if (val_len < 31) val_len++;
		if (b >= "0" && b <= "9") begin
			d = 64'(b - "0");
			if (len_acc > (ALL_ONES - d) / 10) vflags &= ~VF_CL;
			else if (vflags & VF_CL) len_acc = len_acc * 10 + d;
		end else begin
			vflags &= ~VF_CL;
		end
		token_feed(b);
	endfunction

	function automatic void value_done();
		token_end();
		if (keys & KEY_CONN) r_ka = (vflags & VF_KA) != 0 && val_len == 10;
		if ((keys & KEY_CLEN) && (vflags & VF_CL)) r_len = len_acc;
		if (keys & KEY_TENC) begin
			if (vflags & VF_CH) r_ch = 1;
			if (vflags & VF_GZ) r_gz = 1;
		end
		if ((keys & KEY_CENC) && (vflags & VF_CE) && val_len == 4) r_gz = 1;
	endfunction

	function automatic resp_t parse_byte(logic [7:0] b);
		resp_t r;
		logic body;
		body = 0;
		case (stage)
			hrhp_pkg::ST_PROTO: begin
				if (b == hrhp_pkg::CH_SP) begin
					if (tok_cnt < 8 || proto_miss) begin
						stage = hrhp_pkg::ST_BAD;
					end else begin
						r_version = ver_pend; stage = hrhp_pkg::ST_CODE;
						code_acc = 0; digits_open = 1;
					end
				end else if (tok_cnt > 8) begin
					stage = hrhp_pkg::ST_BAD;
				end else begin
					if (tok_cnt < 7) begin
						if (b != proto_str[tok_cnt]) proto_miss = 1;
					end else if (tok_cnt == 7) begin
						if (b == "1") ver_pend = 2;
						else if (b == "0") ver_pend = 1;
						else proto_miss = 1;
					end
					tok_cnt++;
				end
			end
			hrhp_pkg::ST_CODE: begin
				if (b == hrhp_pkg::CH_SP) begin
					if (code_acc == 0) begin
						stage = hrhp_pkg::ST_BAD;
					end else begin
						r_code = 16'(code_acc); stage = hrhp_pkg::ST_TEXT; tok_cnt = 0;
					end
				end else if (ctl_byte(b)) begin
					stage = hrhp_pkg::ST_BAD;
				end else if (digits_open && b >= "0" && b <= "9") begin
					code_acc = code_acc * 10 + 32'(b - "0");
					if (code_acc > 65535) code_acc = 65535;
				end else begin
					digits_open = 0;
				end
			end
			hrhp_pkg::ST_TEXT: begin
				if (b == hrhp_pkg::CH_CR) stage = hrhp_pkg::ST_NL1;
				else if (tok_cnt > TEXT_LIMIT) stage = hrhp_pkg::ST_BAD;
				else tok_cnt++;
			end
			hrhp_pkg::ST_NL1, hrhp_pkg::ST_NL2: begin
				if (b == hrhp_pkg::CH_LF) begin
					stage = hrhp_pkg::ST_KEY; keys = 4'hf; key_len = 0;
				end else begin
					stage = hrhp_pkg::ST_BAD;
				end
			end
			hrhp_pkg::ST_KEY: begin
				if (b == hrhp_pkg::CH_CR) begin
					stage = key_len > 0 ? hrhp_pkg::ST_BAD : hrhp_pkg::ST_NL3;
				end else if (b == hrhp_pkg::CH_COLON) begin
					for (int i = 0; i < 4; i++)
						if (key_len != key_names[i].len()) keys[i] = 0;
					vflags = VF_KA | VF_CE | VF_CL; val_len = 0; len_acc = 0;
					token_reset();
					stage = hrhp_pkg::ST_SPACE;
				end else if (ctl_byte(b)) begin
					stage = hrhp_pkg::ST_BAD;
				end else begin
					for (int i = 0; i < 4; i++)
						if (!(key_len < key_names[i].len() && key_names[i][key_len] == to_lower(b)))
							keys[i] = 0;
					if (key_len < 31) key_len++;
				end
			end
			hrhp_pkg::ST_SPACE:
				stage = b == hrhp_pkg::CH_SP ? hrhp_pkg::ST_VALUE : hrhp_pkg::ST_BAD;
			hrhp_pkg::ST_VALUE: begin
				if (b == hrhp_pkg::CH_CR) begin
					value_done(); stage = hrhp_pkg::ST_NL2;
				end else if (ctl_byte(b)) begin
					stage = hrhp_pkg::ST_BAD;
				end else begin
					value_byte(b);
				end
			end
			hrhp_pkg::ST_NL3: begin
				if (b == hrhp_pkg::CH_LF)
					stage = ((!r_ch && r_len == 0) || cfg_head) ? hrhp_pkg::ST_DONE
						: hrhp_pkg::ST_BODY;
				else
					stage = hrhp_pkg::ST_BAD;
			end
			hrhp_pkg::ST_BODY: begin
				if (body_count >= cfg_max) begin
					stage = hrhp_pkg::ST_LARGE;
				end else begin
					body_count++; body = 1;
					if (body_count >= r_len) stage = hrhp_pkg::ST_DONE;
				end
			end
			default: ;
		endcase
		case (stage)
			hrhp_pkg::ST_BAD: r.status = hrhp_pkg::STAT_BAD;
			hrhp_pkg::ST_LARGE: r.status = hrhp_pkg::STAT_LARGE;
			hrhp_pkg::ST_DONE: r.status = hrhp_pkg::STAT_DONE;
			default: r.status = hrhp_pkg::STAT_CONT;
		endcase
		r.body_valid = body;
		r.body_byte = body ? b : 8'd0;
		r.version = r_version;
		r.http_code = r_code;
		r.keep_alive = r_ka;
		r.chunked = r_ch;
		r.gzip = r_gz;
		r.body_length = r_len;
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cyc);
		errors++;
	endtask

	// input and output transfers, prediction and comparison
	always @(posedge clk) begin
		resp_t got, want;
		cyc <= cyc + 1;
		if (cyc > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			s_fire <= s_axis_tvalid && s_axis_tready;
			cfg_fire <= cfg_valid && cfg_ready;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == hrhp_pkg::CFG_IDX_W'(hrhp_pkg::CFG_HEAD))
					cfg_head = cfg_data[0];
				else if (cfg_index == hrhp_pkg::CFG_IDX_W'(hrhp_pkg::CFG_MAX))
					cfg_max = cfg_data;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = m_axis_tdata[1:0];
				got.body_valid = m_axis_tdata[2];
				got.body_byte = m_axis_tdata[10:3];
				got.version = m_axis_tdata[12:11];
				got.http_code = m_axis_tdata[28:13];
				got.keep_alive = m_axis_tdata[29];
				got.chunked = m_axis_tdata[30];
				got.gzip = m_axis_tdata[31];
				got.body_length = m_axis_tdata[95:32];
				results_out++;
				if (got.body_valid) body_seen++;
				if (expected_resp.size() == 0) begin
					report("unexpected result", 64'd0, 64'd0);
				end else begin
					want = expected_resp.pop_front();
					if (got.status !== want.status)
						report("status", 64'(got.status), 64'(want.status));
					if (got.body_valid !== want.body_valid)
						report("body_valid", 64'(got.body_valid), 64'(want.body_valid));
					if (got.body_byte !== want.body_byte)
						report("body_byte", 64'(got.body_byte), 64'(want.body_byte));
					if (got.version !== want.version)
						report("version", 64'(got.version), 64'(want.version));
					if (got.http_code !== want.http_code)
						report("http_code", 64'(got.http_code), 64'(want.http_code));
					if (got.keep_alive !== want.keep_alive)
						report("keep_alive", 64'(got.keep_alive), 64'(want.keep_alive));
					if (got.chunked !== want.chunked)
						report("chunked", 64'(got.chunked), 64'(want.chunked));
					if (got.gzip !== want.gzip)
						report("gzip", 64'(got.gzip), 64'(want.gzip));
					if (got.body_length !== want.body_length)
						report("body_length", got.body_length, want.body_length);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				bytes_in++;
				expected_resp.push_back(parse_byte(s_axis_tdata));
			end
		end
	end

	function automatic logic quiet_window();
		return cyc >= 500 && cyc < 800;
	endfunction

	// sender side
	int settle = 0;
	always @(negedge clk) begin
		logic nv, ncv;
		logic [7:0] nd;
		nv = s_axis_tvalid; nd = s_axis_tdata; ncv = cfg_valid;
		if (arst_n) begin
			if (cfg_valid && !cfg_fire) begin
				ncv = 1;
			end else if (s_axis_tvalid && !s_fire) begin
				ncv = 0;
			end else begin
				ncv = 0; nv = 0;
				if (pending.size() != 0) begin
					if (pending[0].kind == P_BYTE) begin
						settle = 0;
						if (quiet_window() || $urandom_range(99) >= 19) begin
							nv = 1; nd = pending[0].value[7:0];
							void'(pending.pop_front());
						end
					end else if (expected_resp.size() == 0 && !m_axis_tvalid && !cfg_valid) begin
						settle++;
						if (settle >= 3) begin
							settle = 0;
							if (pending[0].kind == P_CFG) begin
								ncv = 1;
								cfg_index <= pending[0].idx;
								cfg_data <= pending[0].value;
							end
							void'(pending.pop_front());
						end
					end
				end
			end
		end
		s_axis_tvalid <= nv;
		s_axis_tdata <= nd;
		cfg_valid <= ncv;
	end

	// receiver side, with one long hold-off
	int rx_cycles = 0;
	always @(negedge clk) begin
		rx_cycles <= rx_cycles + 1;
		if (!arst_n) m_axis_tready <= 1'b0;
		else if (rx_cycles >= 300 && rx_cycles < 400) m_axis_tready <= 1'b0;
		else if (quiet_window()) m_axis_tready <= 1'b1;
		else m_axis_tready <= $urandom_range(99) >= 19;
	end

	task automatic put_byte(logic [7:0] b);
		pending.push_back('{P_BYTE, 8'd0, {56'd0, b}});
		bytes_queued++;
	endtask

	task automatic put_str(string s);
		for (int i = 0; i < s.len(); i++) put_byte(s[i]);
	endtask

	task automatic put_cfg(logic [7:0] idx, logic [63:0] v);
		pending.push_back('{P_CFG, idx, v});
	endtask

	function automatic logic [7:0] value_char();
		logic [7:0] c;
		case ($urandom_range(9))
			0: c = hrhp_pkg::CH_COMMA;
			1: c = hrhp_pkg::CH_SEMI;
			2: c = hrhp_pkg::CH_SP;
			3: c = 8'($urandom_range(8'hfe, 8'h80));
			4: c = 8'($urandom_range("9", "0"));
			default: c = 8'($urandom_range(8'h7e, 8'h21));
		endcase
		return c;
	endfunction

	function automatic string mixed_case(string s);
		string t;
		t = s;
		for (int i = 0; i < t.len(); i++)
			if (t[i] >= "a" && t[i] <= "z" && $urandom_range(1)) t[i] = t[i] - 8'd32;
		return t;
	endfunction

	task automatic put_random_header();
		int n;
		logic [7:0] c;
		case ($urandom_range(5))
			0: put_str(mixed_case(key_names[$urandom_range(3)]));
			1: put_str(key_names[$urandom_range(3)].substr(0, $urandom_range(8, 3)));
			default: begin
				n = $urandom_range(12, 1);
				for (int i = 0; i < n; i++) begin
					c = 8'($urandom_range(8'hfe, 8'h21));
					if (c == hrhp_pkg::CH_COLON || c == 8'h7f) c = "x";
					put_byte(c);
				end
			end
		endcase
		put_str(": ");
		case ($urandom_range(7))
			0: put_str(mixed_case("keep-alive"));
			1: put_str(mixed_case(" gzip ; chunked"));
			2: put_str(mixed_case("gzip"));
			3: put_str($sformatf("%0d", $urandom_range(5000)));
			4: put_str("chunk ed, gzipx");
			default: begin
				n = $urandom_range(20);
				for (int i = 0; i < n; i++) put_byte(value_char());
			end
		endcase
		put_str("\r\n");
	endtask

	initial begin
		put_cfg(hrhp_pkg::CFG_IDX_W'(hrhp_pkg::CFG_HEAD), 64'd1);
		put_cfg(hrhp_pkg::CFG_IDX_W'(hrhp_pkg::CFG_MAX), 64'd0);
		// status line: unchecked ninth protocol byte, saturating code, longest text
		put_str("HTTP/1.1x 070000ab1 ");
		for (int i = 0; i <= TEXT_LIMIT; i++)
			put_byte(i % 3 == 0 ? 8'($urandom_range(8'hff, 8'h80)) : "a");
		put_str("\r\n");
		put_str(": empty key\r\n");
		put_str("Content-Length: 99999999999999999999\r\n");
		put_str("Content-Length: \r\n");
		put_str("CONNECTION: Keep-Alive\r\n");
		put_str("Transfer-Encoding: gzip ,  chunked;q\r\n");
		put_str("Content-Encoding: gzip\r\n");
		put_cfg(hrhp_pkg::CFG_IDX_W'(hrhp_pkg::CFG_HEAD), 64'd0);
		put_cfg(hrhp_pkg::CFG_IDX_W'(hrhp_pkg::CFG_MAX), ALL_ONES);
		for (int i = 0; i < RANDOM_HEADERS; i++) put_random_header();
		pending.push_back('{P_PAUSE, 8'd0, 64'd0});
		put_str("Connection: keep-alive\r\n");
		put_str("Content-Length: 100000\r\n\r\n");
		for (int i = 0; i < 200; i++) put_byte(8'($urandom_range(255)));
		put_cfg(hrhp_pkg::CFG_IDX_W'(hrhp_pkg::CFG_MAX), 64'd250);
		for (int i = 0; i < 80; i++) put_byte(8'($urandom_range(255)));

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		wait (bytes_in == bytes_queued && expected_resp.size() == 0);
		repeat (20) @(posedge clk);
		$display("parsed %0d bytes: status line, %0d header lines, %0d body bytes passed",
			bytes_in, RANDOM_HEADERS + 8, body_seen);
		$display("%0d results checked, ended with payload limit, %0d mismatches",
			results_out, errors);
		if (errors == 0 && expected_resp.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
